// File: rtl/fxa_pkg.sv
// Package for the fixed-point ALU with power and n-th root.
// Holds the operation codes and the default parameter values; no dependencies.
package fxa_pkg;

	localparam int unsigned DEF_SCALE          = 1000;
	localparam int unsigned DEF_MAX_ROOT_STEPS = 64;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_POW  = 3'd4,
		OP_ROOT = 3'd5
	} op_t;

endpackage

// File: rtl/fxa_mul.sv
// Multi-cycle signed 32 x 32 multiplier, one 16 x 32 partial product a cycle.
// Depends on nothing.
module fxa_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               done,
	output logic signed [63:0] prod
);

	logic               busy_q;
	logic               phase_q;
	logic        [31:0] ma_q;
	logic        [31:0] mb_q;
	logic               neg_q;
	logic        [63:0] acc_q;
	logic        [48:0] part;

	assign part = {1'b0, (phase_q ? ma_q[31:16] : ma_q[15:0])} * {17'd0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
			end else if (busy_q) begin
				phase_q <= 1'b1;
				if (phase_q) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[31] ? 32'(-a) : 32'(a);
			mb_q  <= b[31] ? 32'(-b) : 32'(b);
			neg_q <= a[31] ^ b[31];
			acc_q <= 64'd0;
		end else if (busy_q) begin
			if (phase_q) begin
				acc_q <= acc_q + {part[47:0], 16'd0};
			end else begin
				acc_q <= acc_q + {15'd0, part};
			end
		end
	end

	assign prod = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

// File: rtl/fxa_div.sv
// Multi-cycle signed 64 / 64 restoring divider, one quotient bit a cycle.
// Truncates toward zero; the divisor is never zero here. No dependencies.
module fxa_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	output logic               done,
	output logic signed [63:0] quot
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] q_q;
	logic [63:0] r_q;
	logic [63:0] d_q;
	logic        neg_q;
	logic [64:0] trial;

	assign trial = {r_q, q_q[63]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[63] ? 64'(-num) : 64'(num);
			d_q   <= den[63] ? 64'(-den) : 64'(den);
			r_q   <= 64'd0;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[62:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

// File: rtl/fixed_point_alu_pow_root_core.sv
// Top level of the fixed-point ALU with integer power and Newton n-th root.
// Uses fxa_pkg, the shared multiplier fxa_mul and the shared divider fxa_div.
//
// One transaction is handled at a time, and in_ready is low while it is at work. Add and
// subtract present their result in the cycle after the transaction is taken. Divide runs
// the serial divider. Multiply runs the two-pass multiplier, then a division by the scale.
// Power does one multiply and scale division per unit of exponent magnitude, plus a
// reciprocal when the exponent is negative. Root first takes the reciprocal of the degree
// n, then runs Newton steps of n-1 multiplies, a division and two more multiplies each,
// for up to MAX_ROOT_STEPS steps, plus a reciprocal for a negative exponent. The result is
// held in an output register until it is taken.
module fixed_point_alu_pow_root_core
	import fxa_pkg::*;
#(
	parameter int unsigned SCALE          = DEF_SCALE,
	parameter int unsigned MAX_ROOT_STEPS = DEF_MAX_ROOT_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [2:0]  mode,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	input  logic signed [7:0]  exponent,
	input  logic signed [31:0] error_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result,
	output logic               error,
	output logic               step_limit_hit
);

	localparam int unsigned SW = $clog2(MAX_ROOT_STEPS + 1);
	localparam logic signed [31:0] ONE     = 32'(SCALE);
	localparam logic signed [63:0] SCALE64 = 64'(SCALE);
	localparam logic signed [63:0] ONE_NUM = SCALE64 * SCALE64;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MULW  = 7'b0000010,
		S_DIVW  = 7'b0000100,
		S_PLOOP = 7'b0001000,
		S_RPOW  = 7'b0010000,
		S_LINW  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	// Where a returning quotient goes.
	typedef enum logic [5:0] {
		T_RES  = 6'b000001,
		T_POW  = 6'b000010,
		T_INV  = 6'b000100,
		T_RPOW = 6'b001000,
		T_RQ   = 6'b010000,
		T_RFIN = 6'b100000
	} dret_t;

	state_t state_q;
	dret_t  dret_q;

	logic signed [31:0] a_q;
	logic        [7:0]  mag_q;
	logic               neg_q;
	logic signed [31:0] x_q;
	logic signed [31:0] r_q;
	logic signed [31:0] q_q;
	logic signed [31:0] inv_q;
	logic        [7:0]  cnt_q;
	logic      [SW-1:0] steps_q;

	logic               mul_start_q;
	logic signed [31:0] mul_a_q;
	logic signed [31:0] mul_b_q;
	logic               mul_done;
	logic signed [63:0] mul_p;
	logic               div_start_q;
	logic signed [63:0] div_n_q;
	logic signed [63:0] div_d_q;
	logic               div_done;
	logic signed [63:0] div_q;

	logic        [7:0]  in_mag;
	logic               root_bad;
	logic        [7:0]  mag_m1;
	logic      [SW-1:0] steps_nx;
	logic signed [31:0] div_w;
	logic signed [31:0] mul_w;

	fxa_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .prod(mul_p)
	);

	fxa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .num(div_n_q), .den(div_d_q),
		.done(div_done), .quot(div_q)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign in_mag    = exponent[7] ? 8'(-exponent) : 8'(exponent);
	assign root_bad  = (in_mag == 8'd0) || (operand_a[31] && !in_mag[0]);
	assign mag_m1    = mag_q - 8'd1;
	assign steps_nx  = steps_q + SW'(1);
	assign div_w     = div_q[31:0];
	assign mul_w     = mul_p[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			dret_q         <= T_RES;
			a_q            <= '0;
			mag_q          <= '0;
			neg_q          <= 1'b0;
			x_q            <= '0;
			r_q            <= '0;
			q_q            <= '0;
			inv_q          <= '0;
			cnt_q          <= '0;
			steps_q        <= '0;
			mul_start_q    <= 1'b0;
			mul_a_q        <= '0;
			mul_b_q        <= '0;
			div_start_q    <= 1'b0;
			div_n_q        <= '0;
			div_d_q        <= '0;
			result         <= '0;
			error          <= 1'b0;
			step_limit_hit <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					a_q            <= operand_a;
					mag_q          <= in_mag;
					neg_q          <= exponent[7];
					result         <= 32'sd0;
					error          <= 1'b0;
					step_limit_hit <= 1'b0;
					dret_q         <= T_RES;
					unique case (mode)
						OP_ADD: begin
							result  <= operand_a + operand_b;
							state_q <= S_OUT;
						end
						OP_SUB: begin
							result  <= operand_a - operand_b;
							state_q <= S_OUT;
						end
						OP_MUL: begin
							mul_a_q     <= operand_a;
							mul_b_q     <= operand_b;
							mul_start_q <= 1'b1;
							state_q     <= S_MULW;
						end
						OP_DIV: begin
							if (operand_b == 32'sd0) begin
								result  <= error_value;
								error   <= 1'b1;
								state_q <= S_OUT;
							end else begin
								div_n_q     <= 64'(operand_a) * SCALE64;
								div_d_q     <= 64'(operand_b);
								div_start_q <= 1'b1;
								state_q     <= S_DIVW;
							end
						end
						OP_POW: begin
							r_q     <= ONE;
							cnt_q   <= in_mag;
							state_q <= S_PLOOP;
						end
						OP_ROOT: begin
							if (root_bad) begin
								result  <= error_value;
								error   <= 1'b1;
								state_q <= S_OUT;
							end else begin
								x_q         <= ONE;
								steps_q     <= '0;
								div_n_q     <= SCALE64;
								div_d_q     <= {56'd0, in_mag};
								dret_q      <= T_INV;
								div_start_q <= 1'b1;
								state_q     <= S_DIVW;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_MULW: if (mul_done) begin
					div_n_q     <= mul_p;
					div_d_q     <= SCALE64;
					div_start_q <= 1'b1;
					state_q     <= S_DIVW;
				end
				S_LINW: if (mul_done) begin
					mul_a_q     <= inv_q;
					mul_b_q     <= mul_w + q_q;
					mul_start_q <= 1'b1;
					dret_q      <= T_RFIN;
					state_q     <= S_MULW;
				end
				S_PLOOP: begin
					if (cnt_q != 8'd0) begin
						mul_a_q     <= r_q;
						mul_b_q     <= a_q;
						cnt_q       <= cnt_q - 8'd1;
						mul_start_q <= 1'b1;
						dret_q      <= T_POW;
						state_q     <= S_MULW;
					end else if (neg_q && r_q != 32'sd0) begin
						div_n_q     <= ONE_NUM;
						div_d_q     <= 64'(r_q);
						div_start_q <= 1'b1;
						dret_q      <= T_RES;
						state_q     <= S_DIVW;
					end else begin
						result  <= neg_q ? 32'sd0 : r_q;
						state_q <= S_OUT;
					end
				end
				S_RPOW: begin
					if (cnt_q != 8'd0) begin
						mul_a_q     <= r_q;
						mul_b_q     <= x_q;
						cnt_q       <= cnt_q - 8'd1;
						mul_start_q <= 1'b1;
						dret_q      <= T_RPOW;
						state_q     <= S_MULW;
					end else if (r_q != 32'sd0) begin
						div_n_q     <= 64'(a_q) * SCALE64;
						div_d_q     <= 64'(r_q);
						div_start_q <= 1'b1;
						dret_q      <= T_RQ;
						state_q     <= S_DIVW;
					end else begin
						q_q         <= 32'sd0;
						mul_a_q     <= x_q;
						mul_b_q     <= {24'd0, mag_m1};
						mul_start_q <= 1'b1;
						state_q     <= S_LINW;
					end
				end
				S_DIVW: if (div_done) begin
					unique case (dret_q)
						T_RES: begin
							result  <= div_w;
							state_q <= S_OUT;
						end
						T_POW: begin
							r_q     <= div_w;
							state_q <= S_PLOOP;
						end
						T_INV: begin
							inv_q   <= div_w;
							r_q     <= ONE;
							cnt_q   <= mag_m1;
							state_q <= S_RPOW;
						end
						T_RPOW: begin
							r_q     <= div_w;
							state_q <= S_RPOW;
						end
						T_RQ: begin
							q_q         <= div_w;
							mul_a_q     <= x_q;
							mul_b_q     <= {24'd0, mag_m1};
							mul_start_q <= 1'b1;
							state_q     <= S_LINW;
						end
						T_RFIN: begin
							x_q     <= div_w;
							steps_q <= steps_nx;
							if (div_w != x_q && steps_nx < SW'(MAX_ROOT_STEPS)) begin
								r_q     <= ONE;
								cnt_q   <= mag_m1;
								state_q <= S_RPOW;
							end else begin
								step_limit_hit <= (div_w != x_q);
								if (!neg_q) begin
									result  <= div_w;
									state_q <= S_OUT;
								end else if (div_w == 32'sd0) begin
									result  <= 32'sd0;
									state_q <= S_OUT;
								end else begin
									div_n_q     <= ONE_NUM;
									div_d_q     <= 64'(div_w);
									div_start_q <= 1'b1;
									dret_q      <= T_RES;
									state_q     <= S_DIVW;
								end
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("result changed while waiting");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while a result is pending");
	a_err_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(error && step_limit_hit))
		else $error("both flags raised");
`endif

endmodule
